// ===== sv/rrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrc_pkg: shared definitions for the regex backtracking-risk checker
// Widths, character codes, verdict and register codes, scan modes and the
// beat structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int MaxPatternLen = 256;
  localparam int LenW          = $clog2(MaxPatternLen + 2);
  localparam int QCountMax     = 256;
  localparam int QCountW       = $clog2(QCountMax + 1);
  localparam int DepthW        = 10;
  localparam int RunW          = 4;
  localparam int ByteW         = 8;
  localparam int VerdictW      = 3;
  localparam int QLimitW       = 8;
  localparam int CfgIndexW     = 1;
  localparam int CfgDataW      = 8;

  localparam logic [LenW-1:0]    LenLimit   = LenW'(MaxPatternLen);
  localparam logic [QCountW-1:0] QCountSat  = QCountW'(QCountMax);
  localparam logic [RunW-1:0]    RunSat     = '1;
  localparam logic signed [DepthW-1:0] DepthMax = {1'b0, {(DepthW-1){1'b1}}};
  localparam logic signed [DepthW-1:0] DepthMin = {1'b1, {(DepthW-1){1'b0}}};

  // Verdict codes
  localparam logic [VerdictW-1:0] VerdictOk     = 3'd0;
  localparam logic [VerdictW-1:0] VerdictLong   = 3'd1;
  localparam logic [VerdictW-1:0] VerdictNested = 3'd2;
  localparam logic [VerdictW-1:0] VerdictAlt    = 3'd3;
  localparam logic [VerdictW-1:0] VerdictWild   = 3'd4;
  localparam logic [VerdictW-1:0] VerdictCount  = 3'd5;

  // Register indexes
  localparam logic [CfgIndexW-1:0] CfgQuantLimit = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgRunLimit   = 1'b1;

  localparam logic [QLimitW-1:0] QuantLimitReset = 8'd20;
  localparam logic [RunW-1:0]    RunLimitReset   = 4'd3;

  // Characters
  localparam logic [ByteW-1:0] ChTerm   = 8'h00;
  localparam logic [ByteW-1:0] ChDot    = 8'h2E;
  localparam logic [ByteW-1:0] ChBar    = 8'h7C;
  localparam logic [ByteW-1:0] ChLBrack = 8'h5B;
  localparam logic [ByteW-1:0] ChRBrack = 8'h5D;
  localparam logic [ByteW-1:0] ChCaret  = 8'h5E;
  localparam logic [ByteW-1:0] ChLParen = 8'h28;
  localparam logic [ByteW-1:0] ChRParen = 8'h29;
  localparam logic [ByteW-1:0] ChPlus   = 8'h2B;
  localparam logic [ByteW-1:0] ChStar   = 8'h2A;
  localparam logic [ByteW-1:0] ChLBrace = 8'h7B;
  localparam logic [ByteW-1:0] ChQuest  = 8'h3F;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;

  typedef enum logic [2:0] {
    ModeNormal,
    ModeEsc,
    ModeClsStart,
    ModeClsCaret,
    ModeClsBody,
    ModeClsEsc
  } scan_mode_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } in_beat_t;

  typedef struct packed {
    logic                valid;
    logic [VerdictW-1:0] verdict;
  } verdict_beat_t;

endpackage

// ===== sv/rrc_in_stage.sv =====
// ----------------------------------------------------------------------------
// rrc_in_stage: pattern input register
// Holds one pattern byte; loads a beat when empty or as the held one advances.
// ----------------------------------------------------------------------------
module rrc_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pattern_valid,
  output logic                     pattern_ready,
  input  logic [rrc_pkg::ByteW-1:0] pattern_byte,
  input  logic                     advance,
  output rrc_pkg::in_beat_t        beat
);

  logic                      valid;
  logic [rrc_pkg::ByteW-1:0] data;

  assign pattern_ready = !valid || advance;
  assign beat.valid    = valid;
  assign beat.data     = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pattern_ready) begin
      valid <= pattern_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pattern_valid && pattern_ready) begin
      data <= pattern_byte;
    end
  end

endmodule

// ===== sv/rrc_scan.sv =====
// ----------------------------------------------------------------------------
// rrc_scan: pattern scan state and verdict logic
// Updates the scan state for each advancing byte; on the terminator forms
// the verdict and clears the scan state. Holds the two limit registers.
// ----------------------------------------------------------------------------
module rrc_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rrc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [rrc_pkg::CfgDataW-1:0]  cfg_data,
  input  rrc_pkg::in_beat_t            beat,
  input  logic                         advance,
  output rrc_pkg::verdict_beat_t       res
);

  logic [rrc_pkg::QLimitW-1:0] quant_limit;
  logic [rrc_pkg::RunW-1:0]    run_limit;

  rrc_pkg::scan_mode_t              mode, mode_next;
  logic signed [rrc_pkg::DepthW-1:0] depth, depth_next;
  logic                             grp_quant, grp_quant_next;
  logic                             grp_alt, grp_alt_next;
  logic                             close_pend, close_pend_next;
  logic [1:0]                       closed_flags, closed_flags_next;
  logic [rrc_pkg::RunW-1:0]         run, run_next;
  logic [rrc_pkg::QCountW-1:0]      qcount, qcount_next;
  logic [rrc_pkg::LenW-1:0]         len, len_next;
  logic [rrc_pkg::ByteW-1:0]        prev, prev_next;
  logic [rrc_pkg::VerdictW-1:0]     latched, latched_next;

  logic [rrc_pkg::ByteW-1:0] b;
  logic                      term;
  logic                      is_quant;
  logic [rrc_pkg::RunW-1:0]  run_inc;

  assign b        = beat.data;
  assign term     = (b == rrc_pkg::ChTerm);
  assign is_quant = (b == rrc_pkg::ChPlus) || (b == rrc_pkg::ChStar) ||
                    (b == rrc_pkg::ChLBrace);
  assign run_inc  = (run != rrc_pkg::RunSat) ? run + 1'b1 : run;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_limit <= rrc_pkg::QuantLimitReset;
      run_limit   <= rrc_pkg::RunLimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrc_pkg::CfgQuantLimit: quant_limit <= cfg_data[rrc_pkg::QLimitW-1:0];
        rrc_pkg::CfgRunLimit:   run_limit   <= cfg_data[rrc_pkg::RunW-1:0];
        default: ;
      endcase
    end
  end

  // Verdict: too long first, then the first latched reject, then the count
  always_comb begin
    res.valid = advance && term;
    if (len > rrc_pkg::LenLimit) begin
      res.verdict = rrc_pkg::VerdictLong;
    end else if (latched != rrc_pkg::VerdictOk) begin
      res.verdict = latched;
    end else if (qcount > {1'b0, quant_limit}) begin
      res.verdict = rrc_pkg::VerdictCount;
    end else begin
      res.verdict = rrc_pkg::VerdictOk;
    end
  end

  always_comb begin
    mode_next         = mode;
    depth_next        = depth;
    grp_quant_next    = grp_quant;
    grp_alt_next      = grp_alt;
    close_pend_next   = close_pend;
    closed_flags_next = closed_flags;
    run_next          = run;
    qcount_next       = qcount;
    len_next          = len;
    prev_next         = prev;
    latched_next      = latched;

    if (term) begin
      mode_next         = rrc_pkg::ModeNormal;
      depth_next        = '0;
      grp_quant_next    = 1'b0;
      grp_alt_next      = 1'b0;
      close_pend_next   = 1'b0;
      closed_flags_next = '0;
      run_next          = '0;
      qcount_next       = '0;
      len_next          = '0;
      prev_next         = '0;
      latched_next      = rrc_pkg::VerdictOk;
    end else begin
      if (len <= rrc_pkg::LenLimit) begin
        len_next = len + 1'b1;
      end

      // Quantifier right after ')' checks the closed group's flags
      if (close_pend) begin
        if ((is_quant || b == rrc_pkg::ChQuest) && latched == rrc_pkg::VerdictOk) begin
          if (closed_flags[0]) begin
            latched_next = rrc_pkg::VerdictNested;
          end else if (closed_flags[1]) begin
            latched_next = rrc_pkg::VerdictAlt;
          end
        end
        close_pend_next   = 1'b0;
        closed_flags_next = '0;
      end

      unique case (mode)
        rrc_pkg::ModeEsc: begin
          mode_next = rrc_pkg::ModeNormal;
        end
        rrc_pkg::ModeClsEsc: begin
          mode_next = rrc_pkg::ModeClsBody;
        end
        rrc_pkg::ModeClsStart, rrc_pkg::ModeClsCaret, rrc_pkg::ModeClsBody: begin
          if (mode == rrc_pkg::ModeClsStart && b == rrc_pkg::ChCaret) begin
            mode_next = rrc_pkg::ModeClsCaret;
          end else if (mode != rrc_pkg::ModeClsBody && b == rrc_pkg::ChRBrack) begin
            // leading ']' is a literal
            mode_next = rrc_pkg::ModeClsBody;
          end else if (b == rrc_pkg::ChRBrack) begin
            mode_next = rrc_pkg::ModeNormal;
          end else if (b == rrc_pkg::ChBslash) begin
            mode_next = rrc_pkg::ModeClsEsc;
          end else begin
            mode_next = rrc_pkg::ModeClsBody;
          end
        end
        rrc_pkg::ModeNormal: begin
          if (b == rrc_pkg::ChBslash) begin
            mode_next = rrc_pkg::ModeEsc;
            run_next  = '0;
          end else if (b == rrc_pkg::ChLBrack) begin
            mode_next = rrc_pkg::ModeClsStart;
            run_next  = '0;
          end else if (b == rrc_pkg::ChLParen) begin
            if (depth != rrc_pkg::DepthMax) depth_next = depth + 1'b1;
            grp_quant_next = 1'b0;
            grp_alt_next   = 1'b0;
            run_next       = '0;
          end else if (b == rrc_pkg::ChRParen) begin
            if (depth != rrc_pkg::DepthMin) depth_next = depth - 1'b1;
            close_pend_next   = 1'b1;
            closed_flags_next = {grp_alt, grp_quant};
            grp_quant_next    = 1'b0;
            grp_alt_next      = 1'b0;
            run_next          = '0;
          end else if (b == rrc_pkg::ChBar) begin
            if (depth > 0) grp_alt_next = 1'b1;
            run_next = '0;
          end else if (is_quant) begin
            if (qcount != rrc_pkg::QCountSat) qcount_next = qcount + 1'b1;
            if (depth > 0) grp_quant_next = 1'b1;
            if (prev == rrc_pkg::ChDot) begin
              run_next = run_inc;
              if (run_inc >= run_limit && latched_next == rrc_pkg::VerdictOk) begin
                latched_next = rrc_pkg::VerdictWild;
              end
            end else begin
              run_next = '0;
            end
          end else if (b != rrc_pkg::ChDot) begin
            run_next = '0;
          end
        end
        default: begin
          mode_next = rrc_pkg::ModeNormal;
        end
      endcase

      prev_next = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= rrc_pkg::ModeNormal;
      depth        <= '0;
      grp_quant    <= 1'b0;
      grp_alt      <= 1'b0;
      close_pend   <= 1'b0;
      closed_flags <= '0;
      run          <= '0;
      qcount       <= '0;
      len          <= '0;
      prev         <= '0;
      latched      <= rrc_pkg::VerdictOk;
    end else if (advance) begin
      mode         <= mode_next;
      depth        <= depth_next;
      grp_quant    <= grp_quant_next;
      grp_alt      <= grp_alt_next;
      close_pend   <= close_pend_next;
      closed_flags <= closed_flags_next;
      run          <= run_next;
      qcount       <= qcount_next;
      len          <= len_next;
      prev         <= prev_next;
      latched      <= latched_next;
    end
  end

endmodule

// ===== sv/rrc_out_stage.sv =====
// ----------------------------------------------------------------------------
// rrc_out_stage: verdict output register
// Holds one verdict beat until the receiver takes it.
// ----------------------------------------------------------------------------
module rrc_out_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  rrc_pkg::verdict_beat_t         res,
  output logic                           free,
  output logic                           verdict_valid,
  input  logic                           verdict_ready,
  output logic [rrc_pkg::VerdictW-1:0]   verdict
);

  logic                         valid;
  logic [rrc_pkg::VerdictW-1:0] data;

  assign free          = !valid || verdict_ready;
  assign verdict_valid = valid;
  assign verdict       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res.valid) begin
      valid <= 1'b1;
    end else if (verdict_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      data <= res.verdict;
    end
  end

endmodule

// ===== sv/regex_redos_risk_checker_unit.sv =====
// ----------------------------------------------------------------------------
// regex_redos_risk_checker_unit: backtracking-risk screen for regex patterns
// Pattern bytes come in on the pattern channel (valid/ready), one per beat; a
// zero byte ends the pattern and yields one verdict beat on the verdict
// channel: 0 accepted, 1 too long, 2 nested quantifier, 3 quantified
// alternation, 4 repeated wildcards, 5 too many quantifiers. Other bytes
// yield nothing.
// The cfg channel writes register 0 (quantifier limit, reset 20) and
// register 1 (quantified-dot run limit, reset 3); write only while idle.
// Throughput: one byte per cycle while no terminator waits for room in the
// verdict register, set by the single scan stage between the input register
// and the verdict register. A verdict is written into the verdict register
// at the edge at which its terminator beat leaves the input register.
// Reset clears the scan state and both stage registers and loads the limit
// registers with their reset values; no pass follows reset, so the first
// byte is taken the cycle after.
// When the receiver stalls, the verdict register holds; a terminator waits
// in the input register and pattern_ready drops until the verdict is taken.
// ----------------------------------------------------------------------------
module regex_redos_risk_checker_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pattern_valid,
  output logic                           pattern_ready,
  input  logic [rrc_pkg::ByteW-1:0]      pattern_byte,
  output logic                           verdict_valid,
  input  logic                           verdict_ready,
  output logic [rrc_pkg::VerdictW-1:0]   verdict,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrc_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [rrc_pkg::CfgDataW-1:0]   cfg_data
);

  rrc_pkg::in_beat_t      beat;
  rrc_pkg::verdict_beat_t res;
  logic                   out_free;
  logic                   beat_term;
  logic                   advance;

  assign cfg_ready = 1'b1;
  assign beat_term = (beat.data == rrc_pkg::ChTerm);
  // a terminator waits for room in the verdict register
  assign advance   = beat.valid && (!beat_term || out_free);

  rrc_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .pattern_valid (pattern_valid),
    .pattern_ready (pattern_ready),
    .pattern_byte  (pattern_byte),
    .advance       (advance),
    .beat          (beat)
  );

  rrc_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .beat      (beat),
    .advance   (advance),
    .res       (res)
  );

  rrc_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .free          (out_free),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

`ifndef SYNTHESIS
  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict <= rrc_pkg::VerdictCount))
    else $error("verdict code out of range");

  a_term_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (advance && beat_term) |=> verdict_valid)
    else $error("terminator advanced without a verdict");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pattern_ready |-> (beat.valid && beat_term && verdict_valid && !verdict_ready))
    else $error("input stalled without a waiting verdict");
`endif

endmodule
